FILE: rtl/core/srp_pkg.sv
`timescale 1ns / 1ps
// Package for the split row partition block: item types, field widths and codes.
// Used by every module of the block and by its checker; depends on nothing.
package srp_pkg;

	localparam int ROW_W       = 24;
	localparam int BIN_W       = 16;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 80;
	localparam int OUT_USED_W  = 73;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

	localparam logic OP_COUNT   = 1'b0;
	localparam logic OP_PLACE   = 1'b1;
	localparam logic KIND_PLACE = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [ROW_W-1:0] row_index;
		logic [BIN_W-1:0] bin_value;
		logic [BIN_W-1:0] split_bin;
		logic             is_leaf;
		logic             node_first;
		logic             node_last;
		logic [ROW_W-1:0] node_offset;
		logic [ROW_W-1:0] left_total;
	} in_item_t;

	typedef struct packed {
		logic             kind;
		logic [ROW_W-1:0] dest_position;
		logic [ROW_W-1:0] row_out;
		logic             goes_right;
		logic [ROW_W-1:0] left_count;
	} out_item_t;

endpackage

FILE: rtl/core/split_row_partition_top.sv
`timescale 1ns / 1ps
// Top level of the split row partition block: stream ports, input and result registers.
// Depends on srp_pkg, srp_in_stage, srp_part_unit and srp_out_stage.
//
// The block takes one row per clock cycle and sustains that rate while the
// result side keeps taking transactions. A row is held in the input register,
// compared and placed there against the left and right counters, and its
// result is loaded into the result register, which drives m_tvalid. The
// counter update, done as the row leaves the input register, is what fixes
// the rate at one row per cycle. Leaf rows and count-mode rows that are not
// the last of their node give no result transaction but still leave the
// input register, even while a result waits. s_tready follows m_tready
// combinationally when both registers are full and the waiting row gives a result.
module split_row_partition_top #(
	parameter int ROW_INDEX_BITS = 24,
	parameter int BIN_BITS       = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// row_index[23:0], bin_value[39:24], split_bin[55:40], is_leaf[56],
	// node_first[57], node_offset[81:58], left_total[105:82], zero[111:106]
	input  logic [srp_pkg::IN_TDATA_W-1:0]      s_tdata,
	// operation[0]
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// dest_position[23:0], row_out[47:24], goes_right[48], left_count[72:49],
	// zero[79:73]
	output logic [srp_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// kind[0]
	output logic                                m_tuser
);
	import srp_pkg::*;

	in_item_t  item_in;
	in_item_t  item_s1;
	out_item_t result;
	out_item_t result_q;
	logic      valid_s1;
	logic      produces;
	logic      room;
	logic      advance;
	logic      load_in;

	always_comb begin
		item_in.operation   = s_tuser;
		item_in.row_index   = s_tdata[23:0];
		item_in.bin_value   = s_tdata[39:24];
		item_in.split_bin   = s_tdata[55:40];
		item_in.is_leaf     = s_tdata[56];
		item_in.node_first  = s_tdata[57];
		item_in.node_last   = s_tlast;
		item_in.node_offset = s_tdata[81:58];
		item_in.left_total  = s_tdata[105:82];
	end

	assign advance  = valid_s1 && (!produces || room);
	assign s_tready = !valid_s1 || advance;
	assign load_in  = s_tvalid && s_tready;

	srp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_in),
		.advance  (advance),
		.item_in  (item_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srp_part_unit #(
		.ROW_INDEX_BITS (ROW_INDEX_BITS),
		.BIN_BITS       (BIN_BITS)
	) u_part (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.advance    (advance),
		.produces   (produces),
		.result     (result)
	);

	srp_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && produces),
		.item_in (result),
		.taken   (m_tready),
		.room    (room),
		.valid_q (m_tvalid),
		.item_q  (result_q)
	);

	assign m_tuser = result_q.kind;
	assign m_tdata = {{OUT_PAD_W{1'b0}}, result_q.left_count, result_q.goes_right,
		result_q.row_out, result_q.dest_position};

endmodule

FILE: rtl/core/srp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the split row partition block.
// Depends on srp_pkg for the input item type.
module srp_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             advance,
	input  srp_pkg::in_item_t item_in,
	output logic             valid_s1,
	output srp_pkg::in_item_t item_s1
);
	import srp_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

FILE: rtl/core/srp_part_unit.sv
`timescale 1ns / 1ps
// Split compare, left and right counters and position arithmetic of the partition block.
// Depends on srp_pkg for the item types and codes.
module srp_part_unit #(
	parameter int ROW_INDEX_BITS = 24,
	parameter int BIN_BITS       = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  srp_pkg::in_item_t  item,
	input  logic              advance,
	output logic              produces,
	output srp_pkg::out_item_t result
);
	import srp_pkg::*;

	localparam int CMP_BITS = (BIN_BITS < BIN_W) ? BIN_BITS : BIN_W;

	logic [ROW_INDEX_BITS-1:0] left_q;
	logic [ROW_INDEX_BITS-1:0] right_q;
	logic [ROW_INDEX_BITS-1:0] lc_base;
	logic [ROW_INDEX_BITS-1:0] rc_base;
	logic [ROW_INDEX_BITS-1:0] lc_next;
	logic [ROW_INDEX_BITS-1:0] rc_next;
	logic [ROW_INDEX_BITS-1:0] pos;
	logic                      right;
	logic                      is_place;

	always_comb begin
		lc_base  = item.node_first ? '0 : left_q;
		rc_base  = item.node_first ? '0 : right_q;
		right    = item.bin_value[CMP_BITS-1:0] > item.split_bin[CMP_BITS-1:0];
		is_place = (item.operation == OP_PLACE);
		lc_next  = right ? lc_base : lc_base + ROW_INDEX_BITS'(1);
		rc_next  = (is_place && right) ? rc_base + ROW_INDEX_BITS'(1) : rc_base;
		if (right) begin
			pos = ROW_INDEX_BITS'(item.node_offset) + ROW_INDEX_BITS'(item.left_total)
				+ rc_base;
		end else begin
			pos = ROW_INDEX_BITS'(item.node_offset) + lc_base;
		end
		produces = item_valid && !item.is_leaf && (is_place || item.node_last);
		result.kind          = is_place ? KIND_PLACE : KIND_COUNT;
		result.dest_position = is_place ? ROW_W'(pos) : '0;
		result.row_out       = item.row_index;
		result.goes_right    = right;
		result.left_count    = is_place ? '0 : ROW_W'(lc_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
		end else if (advance && !item.is_leaf) begin
			left_q  <= lc_next;
			right_q <= rc_next;
		end
	end

endmodule

FILE: rtl/core/srp_out_stage.sv
`timescale 1ns / 1ps
// Result register of the split row partition block.
// Depends on srp_pkg for the result item type.
module srp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  srp_pkg::out_item_t  item_in,
	input  logic               taken,
	output logic               room,
	output logic               valid_q,
	output srp_pkg::out_item_t  item_q
);
	import srp_pkg::*;

	assign room = !valid_q || taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (taken) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_in;
		end
	end

endmodule

FILE: rtl/core/srp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for split_row_partition_top, attached by the bind below.
// Depends on srp_pkg for widths and result codes.
module srp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [srp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);
	import srp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result transaction changed or was dropped.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input stalled while the result register was empty.");

	a_count_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_COUNT |-> m_tdata[23:0] == 24'd0)
		else $error("Left-count result carries a nonzero position.");

	a_place_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PLACE |-> m_tdata[72:49] == 24'd0)
		else $error("Placement result carries a nonzero left count.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
		else $error("Result padding bits are not zero.");

endmodule

bind split_row_partition_top srp_checker u_srp_checker (.*);
